/* design/ypc_pkg.sv */
// Package: shared constants and types for the yaw/pitch camera pose block.
package ypc_pkg;

   localparam int TWO_PI_Q12      = 25736;
   localparam int PI_Q12          = 12868;
   localparam int HALF_PI_Q12     = 6434;
   localparam int PITCH_LIMIT_Q12 = 6431;
   localparam int PX_TO_RAD_Q16   = 46851;
   localparam int GAIN_Q30        = 652032874;
   localparam int ONE_Q14         = 16384;
   localparam int ATAN_ENTRIES    = 24;

   // Register indexes of the configuration port
   localparam logic [2:0] REG_H_SENS      = 3'd0;
   localparam logic [2:0] REG_V_SENS      = 3'd1;
   localparam logic [2:0] REG_START_X     = 3'd2;
   localparam logic [2:0] REG_START_Y     = 3'd3;
   localparam logic [2:0] REG_START_Z     = 3'd4;
   localparam logic [2:0] REG_START_YAW   = 3'd5;
   localparam logic [2:0] REG_START_PITCH = 3'd6;

   // Item kinds
   localparam logic [1:0] KIND_TURN = 2'd0;
   localparam logic [1:0] KIND_MOVE = 2'd1;
   localparam logic [1:0] KIND_OFFS = 2'd2;

   // Arctangent table, Q2.30
   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'h3243F6A8;
         5'd1:  r = 32'h1DAC6705;
         5'd2:  r = 32'h0FADBAFC;
         5'd3:  r = 32'h07F56EA6;
         5'd4:  r = 32'h03FEAB76;
         5'd5:  r = 32'h01FFD55B;
         5'd6:  r = 32'h00FFFAAA;
         5'd7:  r = 32'h007FFF55;
         5'd8:  r = 32'h003FFFEA;
         5'd9:  r = 32'h001FFFFD;
         5'd10: r = 32'h000FFFFF;
         5'd11: r = 32'h0007FFFF;
         5'd12: r = 32'h0003FFFF;
         5'd13: r = 32'h0001FFFF;
         5'd14: r = 32'h0000FFFF;
         5'd15: r = 32'h00007FFF;
         5'd16: r = 32'h00003FFF;
         5'd17: r = 32'h00001FFF;
         5'd18: r = 32'h00000FFF;
         5'd19: r = 32'h000007FF;
         5'd20: r = 32'h000003FF;
         5'd21: r = 32'h000001FF;
         5'd22: r = 32'h000000FF;
         5'd23: r = 32'h0000007F;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

   // Clamp a Q1.14 value into +-1.0
   function automatic logic signed [15:0] clamp_unit(input logic signed [35:0] v);
      logic signed [15:0] r;
      if (v > 36'sd16384) r = 16'sd16384;
      else if (v < -36'sd16384) r = -16'sd16384;
      else r = v[15:0];
      return r;
   endfunction

   // Wrap one step of 2*pi (input stays within +-4*pi for all uses)
   function automatic logic signed [17:0] wrap_once(input logic signed [17:0] a);
      logic signed [17:0] r;
      if (a > 18'sd25736) r = a - 18'sd25736;
      else if (a < -18'sd25736) r = a + 18'sd25736;
      else r = a;
      return r;
   endfunction

endpackage

/* design/yaw_pitch_camera_pose_top.sv */
// Top level: camera pose keeper with iterative CORDIC and a serial multiply unit.
//
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/req_stall| kind, mouse deltas, move amounts, offsets
//   rsp_    | out       | rsp_valid/rsp_stall| pose, look vector, up vector
//   csr_    | in        | csr_valid/csr_ready| csr_index, csr_wdata
//
// One transaction at a time. A CORDIC pass runs prepare, the micro-rotations and
// a store; a product runs load, 36 serial steps and store on the one shared
// multiplier. An offset or no-op item takes two CORDIC passes and six products,
// a turn two products more and a move twelve more.
// Reset is synchronous, with no clearing pass. A result held
// under rsp_stall keeps its payload; the next request waits for it to leave.
module yaw_pitch_camera_pose_top
   import ypc_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic signed [8:0]  req_h_offset_px,
   input  logic signed [8:0]  req_v_offset_px,
   input  logic signed [15:0] req_right_amount,
   input  logic signed [15:0] req_up_amount,
   input  logic signed [15:0] req_forward_amount,
   input  logic [15:0]        req_speed,
   input  logic signed [31:0] req_dx,
   input  logic signed [31:0] req_dy,
   input  logic signed [31:0] req_dz,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic signed [15:0] rsp_out_yaw,
   output logic signed [13:0] rsp_out_pitch,
   output logic signed [15:0] rsp_look_x,
   output logic signed [15:0] rsp_look_y,
   output logic signed [15:0] rsp_look_z,
   output logic signed [15:0] rsp_up_x,
   output logic signed [15:0] rsp_up_y,
   output logic signed [15:0] rsp_up_z,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int STEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
   localparam int SW    = $clog2(STEPS + 1);
   localparam int MW    = 36;   // serial multiplier operand width
   localparam int MCW   = 6;

   // Sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_TURN1 = 4'd1;
   localparam logic [3:0] S_TURN2 = 4'd2;
   localparam logic [3:0] S_CPREP = 4'd3;
   localparam logic [3:0] S_CRUN  = 4'd4;
   localparam logic [3:0] S_CDONE = 4'd5;
   localparam logic [3:0] S_MSET  = 4'd6;
   localparam logic [3:0] S_MRUN  = 4'd7;
   localparam logic [3:0] S_MDONE = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   // Multiply operation list
   localparam logic [4:0] OP_DH   = 5'd0;
   localparam logic [4:0] OP_DV   = 5'd1;
   localparam logic [4:0] OP_LX   = 5'd2;
   localparam logic [4:0] OP_LZ   = 5'd3;
   localparam logic [4:0] OP_UX   = 5'd4;
   localparam logic [4:0] OP_UY1  = 5'd5;
   localparam logic [4:0] OP_UY2  = 5'd6;
   localparam logic [4:0] OP_UZ   = 5'd7;
   // Move products per axis: right, up and look terms
   localparam logic [4:0] OP_MRX  = 5'd8;
   localparam logic [4:0] OP_MUX  = 5'd9;
   localparam logic [4:0] OP_MLX  = 5'd10;
   localparam logic [4:0] OP_MRY  = 5'd11;
   localparam logic [4:0] OP_MUY  = 5'd12;
   localparam logic [4:0] OP_MLY  = 5'd13;
   localparam logic [4:0] OP_MRZ  = 5'd14;
   localparam logic [4:0] OP_MUZ  = 5'd15;
   localparam logic [4:0] OP_MLZ  = 5'd16;
   // Speed scalings
   localparam logic [4:0] OP_SX   = 5'd17;
   localparam logic [4:0] OP_SY   = 5'd18;
   localparam logic [4:0] OP_SZ   = 5'd19;

   logic [3:0] state_ff, state_in;

   logic [6:0] hsens_ff, vsens_ff;
   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic signed [15:0] yaw_ff;
   logic signed [13:0] pitch_ff;

   // Latched request
   logic [1:0] kind_ff;
   logic signed [8:0] hpx_ff, vpx_ff;
   logic signed [15:0] ramt_ff, uamt_ff, famt_ff;
   logic [15:0] spd_ff;
   logic signed [31:0] dx_ff, dy_ff, dz_ff;

   // Trig results
   logic signed [15:0] sy_ff, cy_ff, sp_ff, cp_ff;
   logic signed [15:0] lx_ff, lz_ff, ux_ff, uy_ff, uz_ff;
   logic signed [35:0] dh_ff, dv_ff, uyp_ff;
   logic signed [35:0] sum_ff [3];

   // CORDIC datapath
   logic signed [33:0] cx_ff, cyv_ff, cz_ff;
   logic [SW-1:0] cstep_ff;
   logic cflip_ff, cwhich_ff;

   // Serial multiplier
   logic signed [MW-1:0] ma_ff;
   logic [MW-1:0] mb_ff;
   logic signed [2*MW-1:0] macc_ff;
   logic [MCW-1:0] mcnt_ff;
   logic [4:0] op_ff;

   // Output register
   logic rsp_valid_ff;

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;

   logic req_take;
   assign req_take = req_valid && !req_stall;

   // Sensitivity saturation
   function automatic logic [6:0] sat_sens(input logic [6:0] v);
      logic [6:0] r;
      if (v == 7'd0) r = 7'd1;
      else if (v > 7'd100) r = 7'd100;
      else r = v;
      return r;
   endfunction

   // Angle reduction before CORDIC
   logic signed [17:0] ang_a, ang_b, ang_c;
   logic ang_flip;
   always_comb begin
      ang_a = cwhich_ff ? 18'(pitch_ff) : 18'(yaw_ff);
      if (ang_a > 18'sd12868) ang_b = ang_a - 18'sd25736;
      else if (ang_a < -18'sd12868) ang_b = ang_a + 18'sd25736;
      else ang_b = ang_a;
      ang_flip = 1'b0;
      ang_c = ang_b;
      if (ang_b > 18'sd6434) begin
         ang_c = ang_b - 18'sd12868;
         ang_flip = 1'b1;
      end else if (ang_b < -18'sd6434) begin
         ang_c = ang_b + 18'sd12868;
         ang_flip = 1'b1;
      end
   end

   // One CORDIC micro-rotation
   logic signed [33:0] cxs, cys, cx_n, cy_n, cz_n, catan;
   always_comb begin
      cxs = cx_ff >>> cstep_ff;
      cys = cyv_ff >>> cstep_ff;
      catan = 34'(atan_q30(5'(cstep_ff)));
      if (!cz_ff[33]) begin
         cx_n = cx_ff - cys;
         cy_n = cyv_ff + cxs;
         cz_n = cz_ff - catan;
      end else begin
         cx_n = cx_ff + cys;
         cy_n = cyv_ff - cxs;
         cz_n = cz_ff + catan;
      end
   end

   // CORDIC rounding to Q1.14 with flip and clamp
   logic signed [35:0] rx, ry;
   logic signed [15:0] cs_res, cc_res;
   always_comb begin
      rx = (36'(cx_ff) + 36'sd32768) >>> 16;
      ry = (36'(cyv_ff) + 36'sd32768) >>> 16;
      if (cflip_ff) begin
         rx = -rx;
         ry = -ry;
      end
      cs_res = clamp_unit(ry);
      cc_res = clamp_unit(rx);
   end

   // Multiply operand selection
   logic signed [MW-1:0] op_a;
   logic [MW-1:0] op_b;
   logic op_b_signed;
   always_comb begin
      op_a = '0;
      op_b = '0;
      op_b_signed = 1'b1;
      case (op_ff)
         OP_DH: begin
            op_a = MW'(hpx_ff) * MW'(signed'({1'b0, hsens_ff}));
            op_b = MW'(PX_TO_RAD_Q16);
         end
         OP_DV: begin
            op_a = MW'(vpx_ff) * MW'(signed'({1'b0, vsens_ff}));
            op_b = MW'(PX_TO_RAD_Q16);
         end
         OP_LX:  begin op_a = MW'(sy_ff); op_b = MW'(cp_ff); end
         OP_LZ:  begin op_a = MW'(cy_ff); op_b = MW'(cp_ff); end
         OP_UX:  begin op_a = -MW'(sy_ff); op_b = MW'(sp_ff); end
         OP_UY1: begin op_a = MW'(sy_ff); op_b = MW'(lx_ff); end
         OP_UY2: begin op_a = MW'(cy_ff); op_b = MW'(lz_ff); end
         OP_UZ:  begin op_a = MW'(cy_ff); op_b = MW'(sp_ff); end
         OP_MRX: begin op_a = MW'(cy_ff); op_b = MW'(ramt_ff); end
         OP_MUX: begin op_a = MW'(ux_ff); op_b = MW'(uamt_ff); end
         OP_MLX: begin op_a = MW'(lx_ff); op_b = MW'(famt_ff); end
         OP_MRY: begin op_a = '0;         op_b = MW'(ramt_ff); end
         OP_MUY: begin op_a = MW'(uy_ff); op_b = MW'(uamt_ff); end
         OP_MLY: begin op_a = MW'(sp_ff); op_b = MW'(famt_ff); end
         OP_MRZ: begin op_a = MW'(sy_ff); op_b = MW'(ramt_ff); end
         OP_MUZ: begin op_a = MW'(uz_ff); op_b = MW'(uamt_ff); end
         OP_MLZ: begin op_a = MW'(lz_ff); op_b = MW'(famt_ff); end
         OP_SX:  begin op_a = sum_ff[0]; op_b = MW'(spd_ff); op_b_signed = 1'b0; end
         OP_SY:  begin op_a = sum_ff[1]; op_b = MW'(spd_ff); op_b_signed = 1'b0; end
         OP_SZ:  begin op_a = sum_ff[2]; op_b = MW'(spd_ff); op_b_signed = 1'b0; end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   // Move sum slot for the current product
   logic [1:0] sum_idx;
   always_comb begin
      unique case (op_ff) inside
         OP_MRX, OP_MUX, OP_MLX: sum_idx = 2'd0;
         OP_MRY, OP_MUY, OP_MLY: sum_idx = 2'd1;
         default:                sum_idx = 2'd2;
      endcase
   end

   // Bit-serial multiply step: one bit of b per cycle, top bit weighted negative for a signed b
   logic signed [2*MW-1:0] madd, mprod;
   always_comb begin
      madd = mb_ff[0] ? (2*MW)'(ma_ff) <<< mcnt_ff : '0;
      if (mcnt_ff == MCW'(MW - 1) && op_b_signed)
         mprod = macc_ff - madd;
      else
         mprod = macc_ff + madd;
   end

   // Rounded views of a finished product
   logic signed [71:0] p14, p16, p20;
   assign p14 = (macc_ff + 72'sd8192) >>> 14;
   assign p16 = (macc_ff + 72'sd32768) >>> 16;
   assign p20 = (macc_ff + 72'sd524288) >>> 20;

   // Turn arithmetic
   logic signed [17:0] np, yaw_sum;
   always_comb begin
      np = 18'(pitch_ff) + 18'(dv_ff);
      if (np > 18'sd6431) np = 18'sd6431;
      else if (np < -18'sd6431) np = -18'sd6431;
      yaw_sum = 18'(yaw_ff) + 18'(dh_ff);
   end

   // Start register decode
   logic signed [17:0] syaw_w;
   logic signed [13:0] spitch_s;
   always_comb begin
      syaw_w = wrap_once(wrap_once(18'(signed'(csr_wdata[15:0]))));
      if (signed'(csr_wdata[13:0]) > 14'sd6434) spitch_s = 14'sd6434;
      else if (signed'(csr_wdata[13:0]) < -14'sd6434) spitch_s = -14'sd6434;
      else spitch_s = signed'(csr_wdata[13:0]);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_take) state_in = (req_kind == KIND_TURN) ? S_MSET : S_CPREP;
         S_TURN1: state_in = S_TURN2;
         S_TURN2: state_in = S_CPREP;
         S_CPREP: state_in = S_CRUN;
         S_CRUN:  if (cstep_ff == SW'(STEPS - 1)) state_in = S_CDONE;
         S_CDONE: state_in = cwhich_ff ? S_MSET : S_CPREP;
         S_MSET:  state_in = S_MRUN;
         S_MRUN:  if (mcnt_ff == MCW'(MW - 1)) state_in = S_MDONE;
         S_MDONE: begin
            if (op_ff == OP_DV) state_in = S_TURN1;
            else if (op_ff == OP_UZ && kind_ff != KIND_MOVE) state_in = S_OUT;
            else if (op_ff == OP_SZ) state_in = S_OUT;
            else state_in = S_MSET;
         end
         S_OUT:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         hsens_ff     <= 7'd50;
         vsens_ff     <= 7'd50;
         px_ff        <= '0;
         py_ff        <= '0;
         pz_ff        <= '0;
         yaw_ff       <= '0;
         pitch_ff     <= '0;
         op_ff        <= OP_DH;
         cwhich_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;

         // Configuration writes: the user issues them only while idle; not enforced here
         if (csr_valid) begin
            unique case (csr_index)
               REG_H_SENS:      hsens_ff <= sat_sens(csr_wdata[6:0]);
               REG_V_SENS:      vsens_ff <= sat_sens(csr_wdata[6:0]);
               REG_START_X:     px_ff <= csr_wdata;
               REG_START_Y:     py_ff <= csr_wdata;
               REG_START_Z:     pz_ff <= csr_wdata;
               REG_START_YAW:   yaw_ff <= syaw_w[15:0];
               REG_START_PITCH: pitch_ff <= spitch_s;
               default: ;
            endcase
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  kind_ff <= req_kind;
                  hpx_ff  <= req_h_offset_px;
                  vpx_ff  <= req_v_offset_px;
                  ramt_ff <= req_right_amount;
                  uamt_ff <= req_up_amount;
                  famt_ff <= req_forward_amount;
                  spd_ff  <= req_speed;
                  dx_ff   <= req_dx;
                  dy_ff   <= req_dy;
                  dz_ff   <= req_dz;
                  op_ff   <= OP_DH;
                  cwhich_ff <= 1'b0;
               end
            end
            S_TURN1: begin
               pitch_ff <= np[13:0];
               yaw_ff   <= 16'(wrap_once(yaw_sum));
            end
            S_TURN2: begin
               yaw_ff   <= 16'(wrap_once(18'(yaw_ff)));
               op_ff    <= OP_LX;
            end
            S_CPREP: begin
               cx_ff    <= 34'(GAIN_Q30);
               cyv_ff   <= '0;
               cz_ff    <= 34'(ang_c) <<< 18;
               cflip_ff <= ang_flip;
               cstep_ff <= '0;
               op_ff    <= OP_LX;
            end
            S_CRUN: begin
               cx_ff    <= cx_n;
               cyv_ff   <= cy_n;
               cz_ff    <= cz_n;
               cstep_ff <= cstep_ff + SW'(1);
            end
            S_CDONE: begin
               if (!cwhich_ff) begin
                  sy_ff <= cs_res;
                  cy_ff <= cc_res;
               end else begin
                  sp_ff <= cs_res;
                  cp_ff <= cc_res;
               end
               cwhich_ff <= !cwhich_ff;
            end
            S_MSET: begin
               ma_ff   <= op_a;
               mb_ff   <= op_b;
               macc_ff <= '0;
               mcnt_ff <= '0;
            end
            S_MRUN: begin
               macc_ff <= mprod;
               mb_ff   <= mb_ff >> 1;
               mcnt_ff <= mcnt_ff + MCW'(1);
            end
            S_MDONE: begin
               op_ff <= op_ff + 5'd1;
               case (op_ff) inside
                  OP_DH:  dh_ff <= 36'(p16);
                  OP_DV:  dv_ff <= 36'(p16);
                  OP_LX:  lx_ff <= clamp_unit(36'(p14));
                  OP_LZ:  lz_ff <= clamp_unit(-clamp_unit(36'(p14)));
                  OP_UX:  ux_ff <= clamp_unit(36'(p14));
                  OP_UY1: uyp_ff <= 36'(macc_ff);
                  OP_UY2: uy_ff <= clamp_unit(36'(((uyp_ff - 36'(macc_ff)) + 36'sd8192) >>> 14));
                  OP_UZ:  uz_ff <= clamp_unit(36'(p14));
                  OP_MRX, OP_MRY, OP_MRZ: sum_ff[sum_idx] <= 36'(macc_ff);
                  OP_MUX, OP_MLX, OP_MUY, OP_MLY, OP_MUZ, OP_MLZ:
                     sum_ff[sum_idx] <= sum_ff[sum_idx] + 36'(macc_ff);
                  OP_SX: px_ff <= px_ff + 32'(p20);
                  OP_SY: py_ff <= py_ff + 32'(p20);
                  OP_SZ: pz_ff <= pz_ff + 32'(p20);
                  default: ;
               endcase
            end
            S_OUT: begin
               if (kind_ff == KIND_OFFS) begin
                  px_ff <= px_ff + dx_ff;
                  py_ff <= py_ff + dy_ff;
                  pz_ff <= pz_ff + dz_ff;
               end
               rsp_valid_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Result register reads pose after the update
   assign rsp_out_x     = px_ff;
   assign rsp_out_y     = py_ff;
   assign rsp_out_z     = pz_ff;
   assign rsp_out_yaw   = yaw_ff;
   assign rsp_out_pitch = pitch_ff;
   assign rsp_look_x    = lx_ff;
   assign rsp_look_y    = sp_ff;
   assign rsp_look_z    = lz_ff;
   assign rsp_up_x      = ux_ff;
   assign rsp_up_y      = uy_ff;
   assign rsp_up_z      = uz_ff;

`ifndef NO_ASSERTIONS
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("request taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_x) && $stable(rsp_look_x)))
      else $error("result changed under stall");
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid) |-> (pitch_ff <= 14'sd6434 && pitch_ff >= -14'sd6434))
      else $error("pitch out of range");
   a_out_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |=> rsp_valid)
      else $error("result not raised");
`endif

endmodule

/* tb/yaw_pitch_camera_pose_top_test.sv */
// Testbench for the camera pose block: directed and random turns, moves and offsets.
module yaw_pitch_camera_pose_top_test
   import ypc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          STEPS      = 16;
   localparam logic [1:0]  KIND_NONE  = 2'd3;
   localparam logic [2:0]  REG_UNUSED = 3'd7;
   localparam int          N_RANDOM   = 1700;
   localparam int          QUIET_FROM = 1500;
   localparam int          HOLD_LONG  = 2000;

   typedef struct {
      logic [1:0]         kind;
      logic signed [8:0]  h_px;
      logic signed [8:0]  v_px;
      logic signed [15:0] right_amt;
      logic signed [15:0] up_amt;
      logic signed [15:0] fwd_amt;
      logic [15:0]        speed;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] dz;
   } motion_type;

   typedef struct packed {
      logic [31:0] x, y, z;
      logic [15:0] yaw;
      logic [13:0] pitch;
      logic [15:0] lx, ly, lz, ux, uy, uz;
   } pose_type;

   // Tracks the camera pose and the poses still owed by the block
   class pose_scoreboard_type;
      logic [31:0] pos_x, pos_y, pos_z;
      int          yaw, pitch, h_sens, v_sens;
      pose_type    pose_q[$];
      int          mismatches;
      int          unexpected;
      int          poses_checked;
      int          turns, moves, offsets, idles;
      longint      atan_tab[24];

      function new();
         atan_tab = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                      64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
                      64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
         pos_x = '0; pos_y = '0; pos_z = '0;
         yaw = 0; pitch = 0; h_sens = 50; v_sens = 50;
      endfunction

      function longint round_shift(longint v, int k);
         return (v + (longint'(1) <<< (k - 1))) >>> k;
      endfunction

      function int unit_clamp(longint v);
         if (v > ONE_Q14) return ONE_Q14;
         if (v < -ONE_Q14) return -ONE_Q14;
         return int'(v);
      endfunction

      function int q14_product(int a, int b);
         return unit_clamp(round_shift(longint'(a) * b, 14));
      endfunction

      function int yaw_wrapped(int a);
         while (a > TWO_PI_Q12 || a < -TWO_PI_Q12)
            a += (a < 0) ? TWO_PI_Q12 : -TWO_PI_Q12;
         return a;
      endfunction

      function int sens_saturated(logic [31:0] v);
         int s;
         s = int'(v[6:0]);
         if (s < 1) return 1;
         if (s > 100) return 100;
         return s;
      endfunction

      // Rotation-mode CORDIC on Q2.30, folded into +-pi/2
      function void sine_cosine(int a, output int s, output int c);
         longint x, y, z, xs, ys;
         bit     flip;
         x = GAIN_Q30; y = 0; flip = 0;
         if (a > PI_Q12) a -= TWO_PI_Q12;
         else if (a < -PI_Q12) a += TWO_PI_Q12;
         if (a > HALF_PI_Q12) begin
            a -= PI_Q12; flip = 1;
         end else if (a < -HALF_PI_Q12) begin
            a += PI_Q12; flip = 1;
         end
         z = longint'(a) * 262144;
         for (int i = 0; i < STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x -= ys; y += xs; z -= atan_tab[i];
            end else begin
               x += ys; y -= xs; z += atan_tab[i];
            end
         end
         x = round_shift(x, 16);
         y = round_shift(y, 16);
         if (flip) begin
            x = -x; y = -y;
         end
         s = unit_clamp(y);
         c = unit_clamp(x);
      endfunction

      function logic [31:0] move_step(longint r, longint u, longint l, motion_type m);
         longint sum;
         sum = r * m.right_amt + u * m.up_amt + l * m.fwd_amt;
         return 32'(round_shift(sum * longint'(m.speed), 20));
      endfunction

      function void write_register(logic [2:0] idx, logic [31:0] v);
         int p;
         case (idx)
            REG_H_SENS:  h_sens = sens_saturated(v);
            REG_V_SENS:  v_sens = sens_saturated(v);
            REG_START_X: pos_x = v;
            REG_START_Y: pos_y = v;
            REG_START_Z: pos_z = v;
            REG_START_YAW: yaw = yaw_wrapped(int'($signed(v[15:0])));
            REG_START_PITCH: begin
               p = int'($signed(v[13:0]));
               if (p > HALF_PI_Q12) p = HALF_PI_Q12;
               if (p < -HALF_PI_Q12) p = -HALF_PI_Q12;
               pitch = p;
            end
            default: ;
         endcase
      endfunction

      // Advance the pose for an accepted transaction and queue the result
      function void note_motion(motion_type m);
         int       dh, dv, np, sy, cy, sp, cp, lx, ly, lz, ux, uy, uz;
         pose_type e;
         if (m.kind == KIND_TURN) begin
            turns++;
            dh = int'(round_shift(longint'(m.h_px) * h_sens * PX_TO_RAD_Q16, 16));
            dv = int'(round_shift(longint'(m.v_px) * v_sens * PX_TO_RAD_Q16, 16));
            np = pitch + dv;
            if (np > PITCH_LIMIT_Q12) np = PITCH_LIMIT_Q12;
            if (np < -PITCH_LIMIT_Q12) np = -PITCH_LIMIT_Q12;
            pitch = np;
            yaw = yaw_wrapped(yaw + dh);
         end
         sine_cosine(yaw, sy, cy);
         sine_cosine(pitch, sp, cp);
         lx = q14_product(sy, cp);
         ly = sp;
         lz = unit_clamp(-longint'(q14_product(cy, cp)));
         ux = unit_clamp(round_shift(-longint'(sy) * ly, 14));
         uy = unit_clamp(round_shift(longint'(sy) * lx - longint'(cy) * lz, 14));
         uz = q14_product(cy, ly);
         if (m.kind == KIND_MOVE) begin
            moves++;
            pos_x += move_step(cy, ux, lx, m);
            pos_y += move_step(0, uy, ly, m);
            pos_z += move_step(sy, uz, lz, m);
         end else if (m.kind == KIND_OFFS) begin
            offsets++;
            pos_x += m.dx;
            pos_y += m.dy;
            pos_z += m.dz;
         end else if (m.kind == KIND_NONE) begin
            idles++;
         end
         e.x = pos_x; e.y = pos_y; e.z = pos_z;
         e.yaw = 16'(yaw); e.pitch = 14'(pitch);
         e.lx = 16'(lx); e.ly = 16'(ly); e.lz = 16'(lz);
         e.ux = 16'(ux); e.uy = 16'(uy); e.uz = 16'(uz);
         pose_q.push_back(e);
      endfunction

      // Compare a delivered pose with the oldest one owed
      function void check_pose(pose_type a);
         pose_type e;
         if (pose_q.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= 10)
               $display("pose delivered with none pending");
            return;
         end
         e = pose_q.pop_front();
         poses_checked++;
         if (a != e) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("pose %0d mismatch", poses_checked);
               $display("  exp x %h y %h z %h yaw %h pitch %h", e.x, e.y, e.z, e.yaw, e.pitch);
               $display("  got x %h y %h z %h yaw %h pitch %h", a.x, a.y, a.z, a.yaw, a.pitch);
               $display("  exp look %h %h %h up %h %h %h", e.lx, e.ly, e.lz, e.ux, e.uy, e.uz);
               $display("  got look %h %h %h up %h %h %h", a.lx, a.ly, a.lz, a.ux, a.uy, a.uz);
            end
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_kind = '0;
   logic signed [8:0]  req_h_offset_px = '0;
   logic signed [8:0]  req_v_offset_px = '0;
   logic signed [15:0] req_right_amount = '0;
   logic signed [15:0] req_up_amount = '0;
   logic signed [15:0] req_forward_amount = '0;
   logic [15:0]        req_speed = '0;
   logic signed [31:0] req_dx = '0;
   logic signed [31:0] req_dy = '0;
   logic signed [31:0] req_dz = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic signed [15:0] rsp_out_yaw;
   logic signed [13:0] rsp_out_pitch;
   logic signed [15:0] rsp_look_x, rsp_look_y, rsp_look_z;
   logic signed [15:0] rsp_up_x, rsp_up_y, rsp_up_z;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   pose_scoreboard_type poses = new();
   int  motions_sent = 0;
   bit  quiet = 0;
   bit  held_long = 0;

   yaw_pitch_camera_pose_top #(.CORDIC_STEPS(STEPS)) uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #60_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Check each accepted result
   always @(posedge clock) begin
      pose_type a;
      if (!reset && rsp_valid && !rsp_stall) begin
         a.x = rsp_out_x; a.y = rsp_out_y; a.z = rsp_out_z;
         a.yaw = rsp_out_yaw; a.pitch = rsp_out_pitch;
         a.lx = rsp_look_x; a.ly = rsp_look_y; a.lz = rsp_look_z;
         a.ux = rsp_up_x; a.uy = rsp_up_y; a.uz = rsp_up_z;
         poses.check_pose(a);
      end
   end

   // Result side back-pressure: random bursts, one long hold, none at the end
   initial begin
      forever begin
         @(negedge clock);
         if (!held_long && poses.poses_checked >= 60) begin
            rsp_stall = 1'b1;
            repeat (HOLD_LONG) @(negedge clock);
            held_long = 1;
         end
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 6) - 1) @(negedge clock);
         end else begin
            rsp_stall = 1'b0;
            if (!quiet) repeat ($urandom_range(0, 20)) @(negedge clock);
         end
      end
   end

   // Offer one transaction, with an optional gap before it; call at a falling edge
   task automatic send_motion(motion_type m);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_kind = m.kind;
      req_h_offset_px = m.h_px;
      req_v_offset_px = m.v_px;
      req_right_amount = m.right_amt;
      req_up_amount = m.up_amt;
      req_forward_amount = m.fwd_amt;
      req_speed = m.speed;
      req_dx = m.dx;
      req_dy = m.dy;
      req_dz = m.dz;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      poses.note_motion(m);
      motions_sent++;
      @(negedge clock);
   endtask

   // Hold off until the block has returned every pose, then write a register
   task automatic write_csr(logic [2:0] idx, logic [31:0] v);
      req_valid = 1'b0;
      while (poses.pose_q.size() != 0) @(negedge clock);
      csr_index = idx;
      csr_wdata = v;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      poses.write_register(idx, v);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic motion_type random_motion();
      motion_type m;
      int         r;
      r = $urandom_range(0, 99);
      m.kind = (r < 40) ? KIND_TURN : (r < 75) ? KIND_MOVE : (r < 95) ? KIND_OFFS : KIND_NONE;
      m.h_px = 9'($urandom);
      m.v_px = 9'($urandom);
      if ($urandom_range(0, 3) == 0) m.v_px = 9'($urandom_range(0, 40)) - 9'sd20;
      m.right_amt = 16'($urandom);
      m.up_amt = 16'($urandom);
      m.fwd_amt = 16'($urandom);
      m.speed = 16'($urandom);
      m.dx = $urandom;
      m.dy = $urandom;
      m.dz = $urandom;
      return m;
   endfunction

   function automatic motion_type blank_motion(logic [1:0] k);
      motion_type m;
      m = '{k, '0, '0, '0, '0, '0, '0, '0, '0, '0};
      return m;
   endfunction

   initial begin
      motion_type m;
      logic [31:0] sens_pick[6] = '{32'd1, 32'd100, 32'd0, 32'd127, 32'd50, 32'd37};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extremes of each kind at reset settings
      m = blank_motion(KIND_NONE);                 send_motion(m);
      m = blank_motion(KIND_TURN); m.h_px = 9'sd255; m.v_px = 9'sd255;   send_motion(m);
      m.h_px = -9'sd255; m.v_px = -9'sd255;        send_motion(m);
      m.v_px = -9'sd255;                           send_motion(m);
      m.h_px = 9'sd255; m.v_px = 9'sd255;          send_motion(m);
      repeat (4) send_motion(m);
      m.h_px = 9'sh100; m.v_px = 9'sh100;          send_motion(m);
      m = blank_motion(KIND_MOVE);
      m.right_amt = 16'sh7FFF; m.up_amt = 16'sh7FFF; m.fwd_amt = 16'sh7FFF;
      m.speed = 16'hFFFF;                          send_motion(m);
      m.right_amt = 16'sh8000; m.up_amt = 16'sh8000; m.fwd_amt = 16'sh8000;
      send_motion(m);
      m.speed = 16'h0000;                          send_motion(m);
      m = blank_motion(KIND_OFFS);
      m.dx = 32'sh7FFFFFFF; m.dy = 32'sh7FFFFFFF; m.dz = 32'sh7FFFFFFF;
      send_motion(m);                              send_motion(m);
      m.dx = 32'sh80000000; m.dy = 32'sh80000000; m.dz = -32'sd1;
      send_motion(m);
      m = blank_motion(KIND_NONE);
      m.h_px = 9'sd100; m.dx = 32'sd5;             send_motion(m);

      // Directed: register extremes, then turns across the clamp and wrap
      write_csr(REG_START_YAW, 32'h0000_8000);
      write_csr(REG_START_PITCH, 32'h0000_1FFF);
      write_csr(REG_H_SENS, 32'd0);
      write_csr(REG_V_SENS, 32'd127);
      write_csr(REG_UNUSED, 32'hFFFF_FFFF);
      m = blank_motion(KIND_TURN); m.h_px = -9'sd255; m.v_px = 9'sd1; send_motion(m);
      write_csr(REG_START_YAW, 32'h0000_7FFF);
      write_csr(REG_START_PITCH, 32'h0000_2000);
      write_csr(REG_H_SENS, 32'd100);
      m.h_px = 9'sd255; m.v_px = -9'sd1;           send_motion(m);
      write_csr(REG_START_YAW, 32'd25736);
      m.h_px = 9'sd1; m.v_px = 9'sd0;              send_motion(m);

      // Random phases, each with fresh settings
      for (int phase = 0; phase < 8; phase++) begin
         write_csr(REG_H_SENS, (phase < 6) ? sens_pick[phase] : $urandom);
         write_csr(REG_V_SENS, (phase < 6) ? sens_pick[5 - phase] : $urandom);
         write_csr(REG_START_X, (phase == 1) ? 32'h7FFF_FFFF :
                                (phase == 2) ? 32'h8000_0000 : $urandom);
         write_csr(REG_START_Y, (phase == 1) ? 32'h8000_0000 : $urandom);
         write_csr(REG_START_Z, (phase == 2) ? 32'h7FFF_FFFF : $urandom);
         write_csr(REG_START_YAW, $urandom);
         write_csr(REG_START_PITCH, $urandom);
         if (phase == 4) write_csr(REG_UNUSED, $urandom);
         for (int n = 0; n < N_RANDOM / 8; n++) begin
            if (phase == 7 && n >= N_RANDOM / 8 - (N_RANDOM - QUIET_FROM)) quiet = 1;
            send_motion(random_motion());
         end
      end
      req_valid = 1'b0;

      while (poses.pose_q.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
      $display("covered %0d transactions: %0d turns, %0d moves, %0d offsets, %0d no-ops",
               motions_sent, poses.turns, poses.moves, poses.offsets, poses.idles);
      $display("checked %0d poses, %0d mismatches, %0d unexpected",
               poses.poses_checked, poses.mismatches, poses.unexpected);
      if (poses.mismatches == 0 && poses.unexpected == 0 && poses.pose_q.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
